// ===== sv/rpi_pkg.sv =====
// Types, constants and helper functions shared by the ray/parallelogram intersect block.
`timescale 1ns / 1ps
package rpi_pkg;

  localparam int CW        = 21;          // coordinate width, Q8.12
  localparam int W_W       = CW + 1;      // corner minus origin
  localparam int P_C_W     = 2 * CW;      // coordinate by coordinate product
  localparam int N_W       = 2 * CW + 1;  // cross product component
  localparam int P_ND_W    = N_W + CW;    // normal component times direction
  localparam int P_NW_W    = N_W + W_W;   // cross component times w
  localparam int DN_W      = P_ND_W + 2;  // n.d, signed
  localparam int NUM_W     = P_NW_W + 2;  // numerators, signed
  localparam int DEN_W     = DN_W;        // |n.d|
  localparam int MAG_W     = NUM_W;       // |numerator|
  localparam int QB        = 33;          // quotient bits kept before saturation
  localparam int OUT_W     = 32;
  localparam int LIM_W     = 31;
  localparam int THR_W     = 32;
  localparam int CFG_W     = 3 * CW;
  localparam int CFG_IDX_W = 3;

  localparam logic [THR_W-1:0] THRESH_RESET = 32'd687;
  localparam logic [QB-1:0]    Q_POS_MAX    = 33'h0_7FFF_FFFF;
  localparam logic [QB-1:0]    Q_NEG_MAX    = 33'h0_8000_0000;
  localparam logic [OUT_W-1:0] OUT_POS_SAT  = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] OUT_NEG_SAT  = 32'h8000_0000;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CORNER,
    CFG_EDGE_U,
    CFG_EDGE_V,
    CFG_U_LIMIT,
    CFG_V_LIMIT,
    CFG_THRESH
  } cfg_e;

  // per-item flags that ride alongside the dividers
  typedef struct packed {
    logic computed;
    logic neg_l;
    logic neg_a;
    logic neg_b;
  } side_t;

  typedef struct packed {
    logic                    computed;
    logic                    hit;
    logic signed [OUT_W-1:0] distance;
    logic signed [OUT_W-1:0] coord_alpha;
    logic signed [OUT_W-1:0] coord_beta;
  } res_t;

  function automatic coord_t unpack_c(input logic [CFG_W-1:0] pk, input int unsigned k);
    return pk[k*CW +: CW];
  endfunction

  // sign and saturate a truncated quotient magnitude
  function automatic logic signed [OUT_W-1:0] sat_q(input logic [QB-1:0] q,
                                                     input logic ovf, input logic neg);
    logic signed [OUT_W-1:0] r;
    if (neg) begin
      if (ovf || q > Q_NEG_MAX) r = OUT_NEG_SAT;
      else                      r = OUT_W'(QB'(0) - q);
    end else begin
      if (ovf || q > Q_POS_MAX) r = OUT_POS_SAT;
      else                      r = q[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/rpi_ray_if.sv =====
// Ray channel: valid/ready handshake with origin and direction payload.
`timescale 1ns / 1ps
interface rpi_ray_if;
  logic            valid;
  logic            ready;
  rpi_pkg::coord_t origin_x;
  rpi_pkg::coord_t origin_y;
  rpi_pkg::coord_t origin_z;
  rpi_pkg::coord_t dir_x;
  rpi_pkg::coord_t dir_y;
  rpi_pkg::coord_t dir_z;
  modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 input ready);
  modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               output ready);
endinterface

// ===== sv/rpi_res_if.sv =====
// Result channel: valid/ready handshake with intersection payload.
`timescale 1ns / 1ps
interface rpi_res_if;
  logic                            valid;
  logic                            ready;
  logic                            computed;
  logic                            hit;
  logic signed [rpi_pkg::OUT_W-1:0] distance;
  logic signed [rpi_pkg::OUT_W-1:0] coord_alpha;
  logic signed [rpi_pkg::OUT_W-1:0] coord_beta;
  modport source(output valid, computed, hit, distance, coord_alpha, coord_beta,
                 input ready);
  modport sink(input valid, computed, hit, distance, coord_alpha, coord_beta,
               output ready);
endinterface

// ===== sv/rpi_front.sv =====
// Geometry front end: products, dot sums, reject flags and magnitudes (six stages).
`timescale 1ns / 1ps
module rpi_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  rpi_pkg::coord_t              origin [3],
  input  rpi_pkg::coord_t              dir [3],
  input  logic [rpi_pkg::CFG_W-1:0]    corner,
  input  logic [rpi_pkg::CFG_W-1:0]    edge_u,
  input  logic [rpi_pkg::CFG_W-1:0]    edge_v,
  input  logic [rpi_pkg::THR_W-1:0]    thr,
  output logic                         out_valid,
  output rpi_pkg::side_t               side,
  output logic [rpi_pkg::MAG_W-1:0]    mag_l,
  output logic [rpi_pkg::MAG_W-1:0]    mag_a,
  output logic [rpi_pkg::MAG_W-1:0]    mag_b,
  output logic [rpi_pkg::DEN_W-1:0]    den_mag
);
  localparam int W_W    = rpi_pkg::W_W;
  localparam int N_W    = rpi_pkg::N_W;
  localparam int P_C_W  = rpi_pkg::P_C_W;
  localparam int P_ND_W = rpi_pkg::P_ND_W;
  localparam int P_NW_W = rpi_pkg::P_NW_W;
  localparam int DN_W   = rpi_pkg::DN_W;
  localparam int NUM_W  = rpi_pkg::NUM_W;
  localparam int DEN_W  = rpi_pkg::DEN_W;
  localparam int MAG_W  = rpi_pkg::MAG_W;

  rpi_pkg::coord_t p [3];
  rpi_pkg::coord_t u [3];
  rpi_pkg::coord_t v [3];
  logic signed [N_W-1:0] n_cfg [3];

  logic [6:1] vld;

  logic signed [W_W-1:0]    w1 [3];
  rpi_pkg::coord_t          d1 [3];
  logic signed [P_ND_W-1:0] nd2 [3];
  logic signed [P_NW_W-1:0] nw2 [3];
  logic signed [P_C_W-1:0]  dva2 [3];
  logic signed [P_C_W-1:0]  dvb2 [3];
  logic signed [P_C_W-1:0]  uda2 [3];
  logic signed [P_C_W-1:0]  udb2 [3];
  logic signed [W_W-1:0]    w2 [3];
  logic signed [DN_W-1:0]   dn3;
  logic signed [NUM_W-1:0]  nw3;
  logic signed [N_W-1:0]    dv3 [3];
  logic signed [N_W-1:0]    ud3 [3];
  logic signed [W_W-1:0]    w3 [3];
  logic signed [P_NW_W-1:0] wdv4 [3];
  logic signed [P_NW_W-1:0] wud4 [3];
  logic [DEN_W-1:0]         dn_mag4;
  logic                     dn_neg4;
  logic signed [NUM_W-1:0]  nw4;
  logic signed [NUM_W-1:0]  a5;
  logic signed [NUM_W-1:0]  b5;
  logic                     par5;
  logic                     behind5;
  logic                     neg_l5;
  logic [MAG_W-1:0]         nw_mag5;
  logic [DEN_W-1:0]         dn_mag5;
  logic                     dn_neg5;

  for (genvar k = 0; k < 3; k++) begin : g_ax
    localparam int J = (k + 1) % 3;
    localparam int L = (k + 2) % 3;

    assign p[k] = rpi_pkg::unpack_c(corner, k);
    assign u[k] = rpi_pkg::unpack_c(edge_u, k);
    assign v[k] = rpi_pkg::unpack_c(edge_v, k);

    // plane normal follows the edge registers
    always_ff @(posedge clk) begin
      n_cfg[k] <= N_W'(u[J]) * N_W'(v[L]) - N_W'(u[L]) * N_W'(v[J]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w1[k]   <= W_W'(p[k]) - W_W'(origin[k]);
        d1[k]   <= dir[k];
        nd2[k]  <= P_ND_W'(n_cfg[k]) * P_ND_W'(d1[k]);
        nw2[k]  <= P_NW_W'(n_cfg[k]) * P_NW_W'(w1[k]);
        dva2[k] <= P_C_W'(d1[J]) * P_C_W'(v[L]);
        dvb2[k] <= P_C_W'(d1[L]) * P_C_W'(v[J]);
        uda2[k] <= P_C_W'(u[J]) * P_C_W'(d1[L]);
        udb2[k] <= P_C_W'(u[L]) * P_C_W'(d1[J]);
        w2[k]   <= w1[k];
        dv3[k]  <= N_W'(dva2[k]) - N_W'(dvb2[k]);
        ud3[k]  <= N_W'(uda2[k]) - N_W'(udb2[k]);
        w3[k]   <= w2[k];
        wdv4[k] <= P_NW_W'(w3[k]) * P_NW_W'(dv3[k]);
        wud4[k] <= P_NW_W'(w3[k]) * P_NW_W'(ud3[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 3: dot sums
      dn3 <= DN_W'(nd2[0]) + DN_W'(nd2[1]) + DN_W'(nd2[2]);
      nw3 <= NUM_W'(nw2[0]) + NUM_W'(nw2[1]) + NUM_W'(nw2[2]);
      // stage 4
      dn_mag4 <= dn3[DN_W-1] ? DEN_W'(-dn3) : DEN_W'(dn3);
      dn_neg4 <= dn3[DN_W-1];
      nw4     <= nw3;
      // stage 5: alpha and beta sums, reject flags and numerator magnitude
      a5      <= NUM_W'(wdv4[0]) + NUM_W'(wdv4[1]) + NUM_W'(wdv4[2]);
      b5      <= NUM_W'(wud4[0]) + NUM_W'(wud4[1]) + NUM_W'(wud4[2]);
      par5    <= (dn_mag4 == '0) || (dn_mag4 < DEN_W'(thr));
      behind5 <= (nw4 != '0) && (nw4[NUM_W-1] != dn_neg4);
      neg_l5  <= nw4[NUM_W-1] ^ dn_neg4;
      nw_mag5 <= nw4[NUM_W-1] ? MAG_W'(-nw4) : MAG_W'(nw4);
      dn_mag5 <= dn_mag4;
      dn_neg5 <= dn_neg4;
      // stage 6
      mag_a         <= a5[NUM_W-1] ? MAG_W'(-a5) : MAG_W'(a5);
      mag_b         <= b5[NUM_W-1] ? MAG_W'(-b5) : MAG_W'(b5);
      mag_l         <= nw_mag5;
      den_mag       <= dn_mag5;
      side.computed <= !par5 && !behind5;
      side.neg_l    <= neg_l5;
      side.neg_a    <= a5[NUM_W-1] ^ dn_neg5;
      side.neg_b    <= b5[NUM_W-1] ^ dn_neg5;
    end
  end

  assign out_valid = vld[6];

endmodule

// ===== sv/rpi_div.sv =====
// Pipelined restoring divider: one quotient bit per stage plus an overflow check stage.
`timescale 1ns / 1ps
module rpi_div #(
  parameter int RESULT_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rpi_pkg::MAG_W-1:0] num,
  input  logic [rpi_pkg::DEN_W-1:0] den,
  output logic [rpi_pkg::QB-1:0]    q,
  output logic                      ovf
);
  localparam int QB    = rpi_pkg::QB;
  localparam int DEN_W = rpi_pkg::DEN_W;
  localparam int SN_W  = rpi_pkg::MAG_W + RESULT_FRAC_BITS;
  localparam int RW    = (SN_W > DEN_W + QB) ? SN_W : DEN_W + QB;

  logic [RW-1:0]    rem [QB+1];
  logic [DEN_W-1:0] dv  [QB+1];
  logic [QB-1:0]    qv  [QB+1];
  logic             ov  [QB+1];

  // quotient of at least 2^QB saturates regardless of the low bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(num) << RESULT_FRAC_BITS;
      dv[0]  <= den;
      qv[0]  <= '0;
      ov[0]  <= (RW'(num) << RESULT_FRAC_BITS) >= (RW'(den) << QB);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    localparam int B = QB - 1 - s;
    logic [RW-1:0] t;
    logic          ge;
    assign t  = RW'(dv[s]) << B;
    assign ge = rem[s] >= t;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]   <= ge ? rem[s] - t : rem[s];
        dv[s+1]    <= dv[s];
        qv[s+1]    <= qv[s] | (QB'(ge) << B);
        ov[s+1]    <= ov[s];
      end
    end
  end

  assign q   = qv[QB];
  assign ovf = ov[QB];

endmodule

// ===== sv/rpi_out.sv =====
// Saturation stage, limit test and output register with skid buffer.
`timescale 1ns / 1ps
module rpi_out (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  rpi_pkg::side_t            side,
  input  logic [rpi_pkg::QB-1:0]    q_l,
  input  logic [rpi_pkg::QB-1:0]    q_a,
  input  logic [rpi_pkg::QB-1:0]    q_b,
  input  logic                      ov_l,
  input  logic                      ov_a,
  input  logic                      ov_b,
  input  logic [rpi_pkg::LIM_W-1:0] u_limit,
  input  logic [rpi_pkg::LIM_W-1:0] v_limit,
  output logic                      en,
  rpi_res_if.source                 res
);
  localparam int OUT_W = rpi_pkg::OUT_W;
  localparam int LIM_W = rpi_pkg::LIM_W;

  logic                    rv;
  logic                    rc;
  logic signed [OUT_W-1:0] rd, ra, rb;
  rpi_pkg::res_t           push_data;
  logic                    push;
  rpi_pkg::res_t           main_q, skid_q;
  logic                    main_v, skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (en) begin
      rv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rc <= side.computed;
      rd <= side.computed ? rpi_pkg::sat_q(q_l, ov_l, side.neg_l) : '0;
      ra <= side.computed ? rpi_pkg::sat_q(q_a, ov_a, side.neg_a) : '0;
      rb <= side.computed ? rpi_pkg::sat_q(q_b, ov_b, side.neg_b) : '0;
    end
  end

  always_comb begin
    push_data.computed    = rc;
    push_data.hit         = rc && !ra[OUT_W-1] && (ra[LIM_W-1:0] <= u_limit)
                               && !rb[OUT_W-1] && (rb[LIM_W-1:0] <= v_limit);
    push_data.distance    = rd;
    push_data.coord_alpha = ra;
    push_data.coord_beta  = rb;
  end

  assign en   = !skid_v;
  assign push = en && rv;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (res.ready || !main_v) begin
      if (skid_v) begin
        main_v <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        main_v <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res.ready || !main_v) begin
      main_q <= skid_v ? skid_q : push_data;
    end else if (push) begin
      skid_q <= push_data;
    end
  end

  assign res.valid       = main_v;
  assign res.computed    = main_q.computed;
  assign res.hit         = main_q.hit;
  assign res.distance    = main_q.distance;
  assign res.coord_alpha = main_q.coord_alpha;
  assign res.coord_beta  = main_q.coord_beta;

endmodule

// ===== sv/ray_parallelogram_intersect.sv =====
// Top level: ray against configured parallelogram, distance and edge coordinates.
// Pipeline: 6 geometry stages, 34 divider stages, 1 saturation stage,
//   then the output register.
// Throughput: one ray per cycle while not stalled; three pipelined dividers, one quotient bit per stage.
// Stall: the whole pipeline holds while the skid entry is full; nothing is dropped.
// Reset (rst, synchronous): clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps
module ray_parallelogram_intersect #(
  parameter int RESULT_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  rpi_ray_if.sink                       ray,
  rpi_res_if.source                     res,
  input  logic                          cfg_wr_en,
  input  logic [rpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpi_pkg::CFG_W-1:0]     cfg_data
);
  localparam int DIV_LAT = rpi_pkg::QB + 1;

  // configuration registers
  logic [rpi_pkg::CFG_W-1:0] corner, edge_u, edge_v;
  logic [rpi_pkg::LIM_W-1:0] u_limit, v_limit;
  logic [rpi_pkg::THR_W-1:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner  <= '0;
      edge_u  <= '0;
      edge_v  <= '0;
      u_limit <= '0;
      v_limit <= '0;
      thr     <= rpi_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      case (rpi_pkg::cfg_e'(cfg_index))
        rpi_pkg::CFG_CORNER:  corner  <= cfg_data;
        rpi_pkg::CFG_EDGE_U:  edge_u  <= cfg_data;
        rpi_pkg::CFG_EDGE_V:  edge_v  <= cfg_data;
        rpi_pkg::CFG_U_LIMIT: u_limit <= cfg_data[rpi_pkg::LIM_W-1:0];
        rpi_pkg::CFG_V_LIMIT: v_limit <= cfg_data[rpi_pkg::LIM_W-1:0];
        rpi_pkg::CFG_THRESH:  thr     <= cfg_data[rpi_pkg::THR_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // single pipeline enable; low only while the output skid entry is occupied
  logic en;
  assign ray.ready = en;

  rpi_pkg::coord_t origin [3];
  rpi_pkg::coord_t dir [3];
  assign origin[0] = ray.origin_x;
  assign origin[1] = ray.origin_y;
  assign origin[2] = ray.origin_z;
  assign dir[0]    = ray.dir_x;
  assign dir[1]    = ray.dir_y;
  assign dir[2]    = ray.dir_z;

  logic                      f_valid;
  rpi_pkg::side_t            f_side;
  logic [rpi_pkg::MAG_W-1:0] f_mag_l, f_mag_a, f_mag_b;
  logic [rpi_pkg::DEN_W-1:0] f_den;

  rpi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ray.valid),
    .origin    (origin),
    .dir       (dir),
    .corner    (corner),
    .edge_u    (edge_u),
    .edge_v    (edge_v),
    .thr       (thr),
    .out_valid (f_valid),
    .side      (f_side),
    .mag_l     (f_mag_l),
    .mag_a     (f_mag_a),
    .mag_b     (f_mag_b),
    .den_mag   (f_den)
  );

  // lambda, alpha and beta share the denominator |n.d|
  logic [rpi_pkg::QB-1:0] q_l, q_a, q_b;
  logic                   ov_l, ov_a, ov_b;

  rpi_div #(.RESULT_FRAC_BITS(RESULT_FRAC_BITS)) u_div_l (
    .clk(clk), .en(en), .num(f_mag_l), .den(f_den), .q(q_l), .ovf(ov_l)
  );
  rpi_div #(.RESULT_FRAC_BITS(RESULT_FRAC_BITS)) u_div_a (
    .clk(clk), .en(en), .num(f_mag_a), .den(f_den), .q(q_a), .ovf(ov_a)
  );
  rpi_div #(.RESULT_FRAC_BITS(RESULT_FRAC_BITS)) u_div_b (
    .clk(clk), .en(en), .num(f_mag_b), .den(f_den), .q(q_b), .ovf(ov_b)
  );

  // flags and valid travel beside the dividers, same depth
  rpi_pkg::side_t   side_sr [DIV_LAT];
  logic [DIV_LAT-1:0] vld_sr;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sr <= '0;
    end else if (en) begin
      vld_sr <= {vld_sr[DIV_LAT-2:0], f_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_sr[0] <= f_side;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_sr[i] <= side_sr[i-1];
      end
    end
  end

  rpi_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld_sr[DIV_LAT-1]),
    .side     (side_sr[DIV_LAT-1]),
    .q_l      (q_l),
    .q_a      (q_a),
    .q_b      (q_b),
    .ov_l     (ov_l),
    .ov_a     (ov_a),
    .ov_b     (ov_b),
    .u_limit  (u_limit),
    .v_limit  (v_limit),
    .en       (en),
    .res      (res)
  );

  // a stalled pipeline always has a result waiting at the output
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !en |-> res.valid) else $error("pipeline stalled with no pending result");

  a_hit_needs_computed: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.hit |-> res.computed) else $error("hit without computed");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.computed |->
      res.distance == '0 && res.coord_alpha == '0 && res.coord_beta == '0)
    else $error("rejected ray carries nonzero fields");

  a_front_hit: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.computed |-> !res.distance[rpi_pkg::OUT_W-1])
    else $error("computed result with negative distance");

endmodule
